[rtl/setc_pkg.sv]
// ----------------------------------------------------------------------------
// setc_pkg
// Shared types and constants for the scope edge trigger capture block.
// ----------------------------------------------------------------------------
package setc_pkg;

    // Capture geometry
    localparam int BUFFER_SAMPLES = 512;
    localparam int SAMPLE_BITS    = 12;
    localparam int POS_BITS       = (BUFFER_SAMPLES > 1) ? $clog2(BUFFER_SAMPLES) : 1;
    localparam int HALF_SAMPLES   = BUFFER_SAMPLES / 2;

    // Fixed port widths
    localparam int SAMPLE_W  = 12;
    localparam int STATUS_W  = 3;
    localparam int INDEX_W   = 9;
    localparam int QUARTER_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // Input operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REARM  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLING_EDGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_OFF  = 2'd2;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd2048;

    // Reported status codes
    localparam logic [STATUS_W-1:0] CS_FIRST_FILL = 3'd0;
    localparam logic [STATUS_W-1:0] CS_RUNNING    = 3'd1;
    localparam logic [STATUS_W-1:0] CS_ARMED      = 3'd2;
    localparam logic [STATUS_W-1:0] CS_TRIGGERED  = 3'd3;
    localparam logic [STATUS_W-1:0] CS_READY      = 3'd4;

    // Quarter codes
    localparam logic [QUARTER_W-1:0] QTR_NONE = 3'd0;

    // Capture state, one-hot
    typedef enum logic [4:0] {
        ST_FIRST_FILL = 5'b00001,
        ST_RUNNING    = 5'b00010,
        ST_ARMED      = 5'b00100,
        ST_TRIGGERED  = 5'b01000,
        ST_READY      = 5'b10000
    } status_t;

    // One result word
    typedef struct packed {
        logic [STATUS_W-1:0]  capture_status;
        logic [INDEX_W-1:0]   trigger_index;
        logic [QUARTER_W-1:0] capture_quarter;
        logic                 write_buffer;
        logic [INDEX_W-1:0]   write_index;
    } result_t;

endpackage

[rtl/scope_edge_trigger_capture.sv]
// ----------------------------------------------------------------------------
// scope_edge_trigger_capture
// Edge trigger over a double-buffered capture of channel-0 samples.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_stall  | operation, sample
//  output  | out_valid / out_stall| capture_status, trigger_index,
//          |                      | capture_quarter, write_buffer, write_index
//  config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One word in per cycle while in_stall is low, one result word out per word in.
//  Each accepted word updates the capture state in the cycle it is taken and its
//  result is registered into the output register, or into the skid while a result waits.
//  The output register is backed by a one-word skid register, so a word is
//  still taken while a result waits; in_stall rises only once the skid is full.
//  Reset clears the capture state and configuration to their defaults;
//  cfg_ready is always high.
//
module scope_edge_trigger_capture
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic [setc_pkg::SAMPLE_W-1:0]      sample,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [setc_pkg::STATUS_W-1:0]      capture_status,
    output logic [setc_pkg::INDEX_W-1:0]       trigger_index,
    output logic [setc_pkg::QUARTER_W-1:0]     capture_quarter,
    output logic                               write_buffer,
    output logic [setc_pkg::INDEX_W-1:0]       write_index,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [setc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [setc_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import setc_pkg::*;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);
    localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(BUFFER_SAMPLES - 1);
    localparam logic [POS_BITS-1:0] HALF_POS = POS_BITS'(HALF_SAMPLES);

    // Configuration
    logic [SAMPLE_W-1:0]  threshold_reg;
    logic                 falling_edge_reg;
    logic                 trigger_off_reg;

    // Capture state
    status_t              status_reg,   status_next;
    logic                 buf_sel_reg,  buf_sel_next;
    logic [POS_BITS-1:0]  pos_reg,      pos_next;
    logic                 fired_early_reg, fired_early_next;
    logic [POS_BITS-1:0]  cap_index_reg, cap_index_next;
    logic [QUARTER_W-1:0] cap_quarter_reg, cap_quarter_next;

    // Output register and skid
    result_t              main_reg, skid_reg;
    logic                 main_valid_reg, skid_valid_reg;
    result_t              result_new;
    logic                 wbuf_new;
    logic [INDEX_W-1:0]   widx_new;

    logic                 in_fire;
    logic                 out_fire;
    logic [SAMPLE_W-1:0]  value;
    logic                 arm;
    logic                 fire;
    logic                 searching;
    logic                 first_half;
    logic                 last_pos;
    logic [STATUS_W-1:0]  status_code;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_fire  = main_valid_reg && !out_stall;

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RESET;
            falling_edge_reg <= 1'b0;
            trigger_off_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:    threshold_reg    <= cfg_data;
                REG_FALLING_EDGE: falling_edge_reg <= cfg_data[0];
                REG_TRIGGER_OFF:  trigger_off_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Trigger search and buffer bookkeeping for the incoming word
    // ------------------------------------------------------------------
    assign value      = sample & SAMPLE_MASK;
    assign first_half = (pos_reg < HALF_POS);
    assign last_pos   = (pos_reg == LAST_POS);
    // Edge compare: rising arms below, fires at/above; falling mirrors
    assign arm        = falling_edge_reg ? (value > threshold_reg) : (value < threshold_reg);
    assign fire       = falling_edge_reg ? (value <= threshold_reg) : (value >= threshold_reg);
    assign searching  = !trigger_off_reg;

    always_comb
    begin
        status_next      = status_reg;
        buf_sel_next     = buf_sel_reg;
        pos_next         = pos_reg;
        fired_early_next = fired_early_reg;
        cap_index_next   = cap_index_reg;
        cap_quarter_next = cap_quarter_reg;
        wbuf_new         = 1'b0;
        widx_new         = '0;

        if (operation == OP_REARM)
        begin
            // Back to first fill; position and buffer carry on
            status_next      = ST_FIRST_FILL;
            fired_early_next = 1'b0;
            cap_index_next   = '0;
            cap_quarter_next = QTR_NONE;
        end
        else if (status_reg != ST_READY)
        begin
            wbuf_new = buf_sel_reg;
            widx_new = INDEX_W'(pos_reg);

            if (searching)
            begin
                if (status_reg == ST_RUNNING && arm)
                    status_next = ST_ARMED;
                else if (status_reg == ST_ARMED && fire)
                begin
                    status_next      = ST_TRIGGERED;
                    cap_index_next   = pos_reg;
                    cap_quarter_next = {1'b0, buf_sel_reg, 1'b0}
                                     + (first_half ? 3'd1 : 3'd2);
                    fired_early_next = first_half;
                end
            end

            if (last_pos)
            begin
                // End of buffer: promote status, swap buffers
                if (status_next == ST_FIRST_FILL)
                    status_next = ST_RUNNING;
                else if (status_next == ST_TRIGGERED)
                begin
                    if (fired_early_next)
                        status_next = ST_READY;
                    else
                        fired_early_next = 1'b1;
                end
                pos_next     = '0;
                buf_sel_next = !buf_sel_reg;
            end
            else
                pos_next = pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        unique case (status_next)
            ST_FIRST_FILL: status_code = CS_FIRST_FILL;
            ST_RUNNING:    status_code = CS_RUNNING;
            ST_ARMED:      status_code = CS_ARMED;
            ST_TRIGGERED:  status_code = CS_TRIGGERED;
            ST_READY:      status_code = CS_READY;
            default:       status_code = CS_FIRST_FILL;
        endcase
    end

    assign result_new.capture_status  = status_code;
    assign result_new.trigger_index   = INDEX_W'(cap_index_next);
    assign result_new.capture_quarter = cap_quarter_next;
    assign result_new.write_buffer    = wbuf_new;
    assign result_new.write_index     = widx_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg      <= ST_FIRST_FILL;
            buf_sel_reg     <= 1'b0;
            pos_reg         <= '0;
            fired_early_reg <= 1'b0;
            cap_index_reg   <= '0;
            cap_quarter_reg <= QTR_NONE;
        end
        else if (in_fire)
        begin
            status_reg      <= status_next;
            buf_sel_reg     <= buf_sel_next;
            pos_reg         <= pos_next;
            fired_early_reg <= fired_early_next;
            cap_index_reg   <= cap_index_next;
            cap_quarter_reg <= cap_quarter_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one-word skid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (main_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (out_fire)
            main_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                main_reg <= skid_reg;
        end
        else if (in_fire)
        begin
            if (main_valid_reg && !out_fire)
                skid_reg <= result_new;
            else
                main_reg <= result_new;
        end
    end

    assign out_valid       = main_valid_reg;
    assign capture_status  = main_reg.capture_status;
    assign trigger_index   = main_reg.trigger_index;
    assign capture_quarter = main_reg.capture_quarter;
    assign write_buffer    = main_reg.write_buffer;
    assign write_index     = main_reg.write_index;

endmodule
